>>> rtl/core/rfwe_pkg.sv
package rfwe_pkg;

  // fixed field widths
  localparam int IDX_W    = 32;
  localparam int LETTER_W = 5;

  // word length limit and default alphabet
  localparam int MAX_LETTERS       = 7;
  localparam int ALPHABET_SIZE_DEF = 26;

  // width of block counts and digit weights (26 * 25^6 needs 33 bits)
  localparam int CNT_W = 34;

  // length counter holds 1 .. MAX_LETTERS, table index 0 .. MAX_LETTERS-1
  localparam int LEN_W = $clog2(MAX_LETTERS + 1);
  localparam int TAB_W = $clog2(MAX_LETTERS);

  // integer power, evaluated at elaboration only
  function automatic logic [63:0] pow_of(input int base, input int e);
    logic [63:0] acc;
    acc = 64'd1;
    for (int i = 0; i < e; i++) begin
      acc = acc * 64'(base);
    end
    return acc;
  endfunction

endpackage

>>> rtl/core/rfwe_cmp_sub.sv
module rfwe_cmp_sub #(
  parameter int B_W = rfwe_pkg::CNT_W
) (
  input  logic [rfwe_pkg::IDX_W-1:0] a,
  input  logic [B_W-1:0]             b,
  output logic                       ge,
  output logic [rfwe_pkg::IDX_W-1:0] diff
);
  import rfwe_pkg::*;

  // compare against the wide operand, subtract only the low bits
  // (the high bits are zero whenever ge is set)
  assign ge   = {{B_W{1'b0}}, a} >= {{IDX_W{1'b0}}, b};
  assign diff = a - b[IDX_W-1:0];

endmodule

>>> rtl/core/run_free_word_encoder_top.sv
// the word length is searched first, then each letter is built bit by bit, one
// quotient bit per cycle unless the output stalls, through a single shared
// compare/subtract unit
// in_ready is high only while no index is being worked on; the last letter
// may still wait in the output register while the next index is taken
// reset: synchronous, active high, clears the sequencer and output valid
module run_free_word_encoder_top #(
  parameter int ALPHABET_SIZE = rfwe_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rfwe_pkg::IDX_W-1:0]    index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rfwe_pkg::LETTER_W-1:0] letter,
  output logic                          last
);
  import rfwe_pkg::*;

  localparam int RADIX1 = ALPHABET_SIZE - 1;
  localparam int DW     = CNT_W + LETTER_W - 1;
  localparam int BIT_W  = $clog2(LETTER_W);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LEN  = 3'b010,
    S_DIG  = 3'b100
  } state_t;

  state_t                state, state_next;
  logic [IDX_W-1:0]      offset, offset_next;
  logic [LEN_W-1:0]      length, length_next;
  logic [LEN_W-1:0]      pos, pos_next;
  logic [BIT_W-1:0]      bit_sel, bit_sel_next;
  logic [LETTER_W-1:0]   quot, quot_next;
  logic [LETTER_W-1:0]   prev, prev_next;
  logic                  out_valid_r, out_valid_next;
  logic [LETTER_W-1:0]   letter_r, letter_next;
  logic                  last_r, last_next;

  // block sizes and digit weights per length, constant
  logic [CNT_W-1:0] count_tab  [MAX_LETTERS];
  logic [CNT_W-1:0] weight_tab [MAX_LETTERS];

  for (genvar e = 0; e < MAX_LETTERS; e++) begin : g_tab
    assign weight_tab[e] = CNT_W'(pow_of(RADIX1, e));
    assign count_tab[e]  = CNT_W'(64'(ALPHABET_SIZE) * pow_of(RADIX1, e));
  end

  // table lookups for the current length and letter position
  logic [TAB_W-1:0] len_idx;
  logic [TAB_W-1:0] exp_idx;
  logic [CNT_W-1:0] count_cur;
  logic [CNT_W-1:0] weight_cur;
  logic [DW-1:0]    trial;
  logic [DW-1:0]    operand;
  logic             ge;
  logic [IDX_W-1:0] diff;

  assign len_idx    = TAB_W'(length - LEN_W'(1));
  assign exp_idx    = TAB_W'(length - LEN_W'(1) - pos);
  assign count_cur  = count_tab[len_idx];
  assign weight_cur = weight_tab[exp_idx];
  assign trial      = DW'(weight_cur) << bit_sel;
  assign operand    = (state == S_LEN) ? DW'(count_cur) : trial;

  // shared compare/subtract unit
  rfwe_cmp_sub #(
    .B_W (DW)
  ) u_cmp_sub (
    .a    (offset),
    .b    (operand),
    .ge   (ge),
    .diff (diff)
  );

  // digit assembly and skip of the left neighbour
  logic [LETTER_W-1:0] quot_set;
  logic [LETTER_W-1:0] code;
  logic                out_free;
  logic                is_last;

  assign quot_set = quot | (LETTER_W'(ge) << bit_sel);
  assign out_free = !out_valid_r || out_ready;
  assign is_last  = (pos == length - LEN_W'(1));

  always_comb begin
    if (pos == '0) begin
      code = quot_set;
    end else if (quot_set < prev) begin
      code = quot_set;
    end else begin
      code = quot_set + LETTER_W'(1);
    end
  end

  // sequencer
  always_comb begin
    state_next     = state;
    offset_next    = offset;
    length_next    = length;
    pos_next       = pos;
    bit_sel_next   = bit_sel;
    quot_next      = quot;
    prev_next      = prev;
    letter_next    = letter_r;
    last_next      = last_r;
    out_valid_next = out_valid_r && !out_ready;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          offset_next = (index == '0) ? '0 : index - IDX_W'(1);
          length_next = LEN_W'(1);
          state_next  = S_LEN;
        end
      end
      S_LEN: begin
        if (ge && length < LEN_W'(MAX_LETTERS)) begin
          offset_next = diff;
          length_next = length + LEN_W'(1);
        end else begin
          // saturate past the last word of the longest length
          if (ge) begin
            offset_next = IDX_W'(count_cur - CNT_W'(1));
          end
          pos_next     = '0;
          bit_sel_next = BIT_W'(LETTER_W - 1);
          quot_next    = '0;
          state_next   = S_DIG;
        end
      end
      S_DIG: begin
        if (bit_sel != '0) begin
          if (ge) begin
            offset_next = diff;
          end
          quot_next    = quot_set;
          bit_sel_next = bit_sel - BIT_W'(1);
        end else if (out_free) begin
          if (ge) begin
            offset_next = diff;
          end
          letter_next    = code;
          last_next      = is_last;
          out_valid_next = 1'b1;
          prev_next      = code;
          pos_next       = pos + LEN_W'(1);
          bit_sel_next   = BIT_W'(LETTER_W - 1);
          quot_next      = '0;
          if (is_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state       <= state_next;
      out_valid_r <= out_valid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    offset   <= offset_next;
    length   <= length_next;
    pos      <= pos_next;
    bit_sel  <= bit_sel_next;
    quot     <= quot_next;
    prev     <= prev_next;
    letter_r <= letter_next;
    last_r   <= last_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_valid_r;
  assign letter    = letter_r;
  assign last      = last_r;

endmodule

>>> rtl/core/rfwe_checker.sv
module rfwe_checker #(
  parameter int ALPHABET_SIZE = rfwe_pkg::ALPHABET_SIZE_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [rfwe_pkg::IDX_W-1:0]    index,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rfwe_pkg::LETTER_W-1:0] letter,
  input logic                          last
);
  import rfwe_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(letter) && $stable(last))
    else $error("output beat changed while stalled");

  // a new index is taken only once the previous word has reached its last letter
  a_word_done: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && out_valid |-> last)
    else $error("index accepted in the middle of a word");

  // busy after taking an index
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready straight after an accepted index");

  // letters stay inside the alphabet
  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(letter) < ALPHABET_SIZE)
    else $error("letter code outside the alphabet");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind run_free_word_encoder_top rfwe_checker #(
  .ALPHABET_SIZE (ALPHABET_SIZE)
) u_rfwe_checker (.*);
